// ===== rtl/fast_inverse_square_root_core_macros.svh =====
// assertion helpers used by the checker file
`ifndef FAST_INVERSE_SQUARE_ROOT_CORE_MACROS_SVH
`define FAST_INVERSE_SQUARE_ROOT_CORE_MACROS_SVH

// plain property, sampled on clk, off during reset
`define FISR_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("fisr assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define FISR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fisr assertion failed");

`endif

// ===== rtl/fisr_pkg.sv =====
`default_nettype none

package fisr_pkg;

    localparam int unsigned PIPE_DEPTH = 16;
    localparam int unsigned Y_DEPTH    = 13;

    localparam logic [31:0] MAGIC_GUESS = 32'h5f3759df;
    localparam logic [31:0] FP_HALF     = 32'h3f000000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
    localparam logic [31:0] FP_DEFAULT_NAN  = 32'hffc00000;
    localparam logic [31:0] FP_QUIET_BIT    = 32'h00400000;

    // unrounded value: p * 2^(e - 127 - 47), leading one expected at bit 47
    typedef struct packed {
        logic               sign;
        logic               spec;
        logic [31:0]        spec_bits;
        logic signed [10:0] e;
        logic [47:0]        p;
    } fmid_t;

    // aligned operands of an addition, big magnitude first
    typedef struct packed {
        logic               sign;
        logic               sub;
        logic               zsign;
        logic               spec;
        logic [31:0]        spec_bits;
        logic signed [10:0] e;
        logic [26:0]        mb;
        logic [26:0]        ms;
    } falign_t;

    function automatic logic is_nan(input logic [31:0] a);
        is_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        is_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] a);
        is_zero = (a[30:0] == 31'd0);
    endfunction

    function automatic fmid_t fmul_pre(input logic [31:0] a, input logic [31:0] b);
        fmid_t       m;
        logic [8:0]  eae;
        logic [8:0]  ebe;
        logic [23:0] ma;
        logic [23:0] mb;
        m.sign      = a[31] ^ b[31];
        eae         = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
        ebe         = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
        ma          = {|a[30:23], a[22:0]};
        mb          = {|b[30:23], b[22:0]};
        m.p         = ma * mb;
        m.e         = $signed({2'b00, eae}) + $signed({2'b00, ebe}) - 11'sd126;
        m.spec      = 1'b1;
        m.spec_bits = 32'd0;
        if (is_nan(a))
            m.spec_bits = a | FP_QUIET_BIT;
        else if (is_nan(b))
            m.spec_bits = b | FP_QUIET_BIT;
        else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
            m.spec_bits = FP_DEFAULT_NAN;
        else if (is_inf(a) || is_inf(b))
            m.spec_bits = {m.sign, 31'h7f800000};
        else if (is_zero(a) || is_zero(b))
            m.spec_bits = {m.sign, 31'd0};
        else
            m.spec = 1'b0;
        fmul_pre = m;
    endfunction

    function automatic falign_t falign(input logic [31:0] a, input logic [31:0] b);
        falign_t     r;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  ebig;
        logic [7:0]  esml;
        logic [7:0]  d;
        logic [26:0] raw;
        logic        stk;
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        ebig   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        esml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d      = ebig - esml;
        raw    = {|sml[30:23], sml[22:0], 3'b000};
        r.mb   = {|big[30:23], big[22:0], 3'b000};
        if (d >= 8'd27)
        begin
            r.ms = 27'd0;
            stk  = |raw;
        end
        else
        begin
            r.ms = raw >> d;
            stk  = |(raw & ((27'd1 << d) - 27'd1));
        end
        r.ms        = r.ms | {26'd0, stk};
        r.sign      = big[31];
        r.sub       = a[31] ^ b[31];
        r.zsign     = a[31] & b[31];
        r.e         = $signed({3'b000, ebig}) + 11'sd1;
        r.spec      = 1'b1;
        r.spec_bits = 32'd0;
        if (is_nan(a))
            r.spec_bits = a | FP_QUIET_BIT;
        else if (is_nan(b))
            r.spec_bits = b | FP_QUIET_BIT;
        else if (is_inf(a) && is_inf(b))
            r.spec_bits = (a[31] != b[31]) ? FP_DEFAULT_NAN : a;
        else if (is_inf(a))
            r.spec_bits = a;
        else if (is_inf(b))
            r.spec_bits = b;
        else
            r.spec = 1'b0;
        falign = r;
    endfunction

    // a - b, a nan subtrahend passes through with its own sign
    function automatic falign_t fsub_align(input logic [31:0] a, input logic [31:0] b);
        falign_t r;
        r = falign(a, {~b[31], b[30:0]});
        if (!is_nan(a) && is_nan(b))
            r.spec_bits = b | FP_QUIET_BIT;
        fsub_align = r;
    endfunction

    function automatic fmid_t fadd_sum(input falign_t al);
        fmid_t       m;
        logic [27:0] s;
        if (al.sub)
            s = {1'b0, al.mb} - {1'b0, al.ms};
        else
            s = {1'b0, al.mb} + {1'b0, al.ms};
        m.sign      = al.sign;
        m.e         = al.e;
        m.p         = {s, 20'd0};
        m.spec      = al.spec;
        m.spec_bits = al.spec_bits;
        // exact cancellation gives +0 unless both operands were -0
        if (!al.spec && (s == 28'd0))
        begin
            m.spec      = 1'b1;
            m.spec_bits = {al.zsign, 31'd0};
        end
        fadd_sum = m;
    endfunction

    function automatic fmid_t fnorm(input fmid_t m);
        fmid_t      n;
        logic [5:0] lz;
        lz = 6'd48;
        for (int i = 0; i < 48; i++)
        begin
            if (m.p[i])
                lz = 6'(47 - i);
        end
        n   = m;
        n.p = m.p << lz;
        n.e = m.e - $signed({5'b00000, lz});
        fnorm = n;
    endfunction

    function automatic logic [31:0] fround(input fmid_t m);
        logic signed [10:0] rs_s;
        logic [5:0]         rs;
        logic [47:0]        sp;
        logic               stk;
        logic [9:0]         ef;
        logic [23:0]        mm;
        logic               inc;
        logic [33:0]        w;
        logic [31:0]        res;
        rs_s = 11'sd1 - m.e;
        rs   = rs_s[5:0];
        if (m.e >= 11'sd1)
        begin
            sp  = m.p;
            stk = 1'b0;
            ef  = m.e[9:0] - 10'd1;
        end
        else if (rs_s >= 11'sd48)
        begin
            sp  = 48'd0;
            stk = |m.p;
            ef  = 10'd0;
        end
        else
        begin
            // subnormal result: denormalize with sticky
            sp  = m.p >> rs;
            stk = |(m.p & ((48'd1 << rs) - 48'd1));
            ef  = 10'd0;
        end
        mm  = sp[47:24];
        inc = sp[23] & (stk | (|sp[22:0]) | mm[0]);
        // hidden bit and rounding carry fold into the exponent field
        w   = {1'b0, ef, 23'd0} + {10'd0, mm} + {33'd0, inc};
        if (w >= {1'b0, 10'd255, 23'd0})
            res = {m.sign, 31'h7f800000};
        else
            res = {m.sign, w[30:0]};
        if (m.spec)
            res = m.spec_bits;
        fround = res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fisr_if.sv =====
`default_nettype none

interface fisr_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_bits;

    modport source (output valid, output x_bits, input ready);
    modport sink (input valid, input x_bits, output ready);
endinterface

interface fisr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] y_bits;

    modport source (output valid, output y_bits, input ready);
    modport sink (input valid, input y_bits, output ready);
endinterface

`default_nettype wire

// ===== rtl/fast_inverse_square_root_core.sv =====
// channel | dir | payload      | handshake
// req     | in  | x_bits [31:0] | valid / ready
// rsp     | out | y_bits [31:0] | valid / ready
//
// sixteen register stages: four float multiplies of three stages each
// (product, normalize, round) and one float subtract of four stages
// one transaction per cycle unless rsp stalls, result delivered from the last stage
// rst_n clears only the stage valid bits, the datapath has no reset
// a stall at rsp freezes every stage; req.ready follows rsp.ready
// whenever the last stage holds a result
`default_nettype none

module fast_inverse_square_root_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    fisr_req_if.sink     req,
    fisr_rsp_if.source   rsp
);

    logic                  en;
    logic [fisr_pkg::PIPE_DEPTH-1:0] v_reg;
    logic [fisr_pkg::PIPE_DEPTH-1:0] v_next;
    logic [31:0]           y_reg [fisr_pkg::Y_DEPTH];
    logic [31:0]           y_next;

    fisr_pkg::fmid_t       s1_reg, s2_reg, s4_reg, s5_reg, s7_reg, s8_reg;
    fisr_pkg::fmid_t       s11_reg, s12_reg, s14_reg, s15_reg;
    fisr_pkg::falign_t     s10_reg;
    logic [31:0]           h_reg, hy_reg, hyy_reg, corr_reg, r_reg;

    assign en        = !v_reg[fisr_pkg::PIPE_DEPTH-1] || rsp.ready;
    assign req.ready = en;
    assign rsp.valid = v_reg[fisr_pkg::PIPE_DEPTH-1];
    assign rsp.y_bits = r_reg;

    // initial guess from the integer view of the input
    assign y_next = fisr_pkg::MAGIC_GUESS - {req.x_bits[31], req.x_bits[31:1]};
    assign v_next = {v_reg[fisr_pkg::PIPE_DEPTH-2:0], req.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg[0] <= y_next;
            for (int i = 1; i < fisr_pkg::Y_DEPTH; i++)
                y_reg[i] <= y_reg[i-1];

            // h = 0.5 * x
            s1_reg  <= fisr_pkg::fmul_pre(fisr_pkg::FP_HALF, req.x_bits);
            s2_reg  <= fisr_pkg::fnorm(s1_reg);
            h_reg   <= fisr_pkg::fround(s2_reg);

            // hy = h * y
            s4_reg  <= fisr_pkg::fmul_pre(h_reg, y_reg[2]);
            s5_reg  <= fisr_pkg::fnorm(s4_reg);
            hy_reg  <= fisr_pkg::fround(s5_reg);

            // hyy = hy * y
            s7_reg  <= fisr_pkg::fmul_pre(hy_reg, y_reg[5]);
            s8_reg  <= fisr_pkg::fnorm(s7_reg);
            hyy_reg <= fisr_pkg::fround(s8_reg);

            // corr = 1.5 - hyy
            s10_reg  <= fisr_pkg::fsub_align(fisr_pkg::FP_THREE_HALVES, hyy_reg);
            s11_reg  <= fisr_pkg::fadd_sum(s10_reg);
            s12_reg  <= fisr_pkg::fnorm(s11_reg);
            corr_reg <= fisr_pkg::fround(s12_reg);

            // r = y * corr
            s14_reg <= fisr_pkg::fmul_pre(y_reg[12], corr_reg);
            s15_reg <= fisr_pkg::fnorm(s14_reg);
            r_reg   <= fisr_pkg::fround(s15_reg);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fisr_checker.sv =====
`default_nettype none

`include "fast_inverse_square_root_core_macros.svh"

module fisr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] y_bits
);

    localparam int unsigned CW = $clog2(fisr_pkg::PIPE_DEPTH + 1);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          in_acc;
    logic          out_acc;

    assign in_acc  = req_valid && req_ready;
    assign out_acc = rsp_valid && rsp_ready;

    // transactions accepted but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc)
            cnt_next = cnt_reg + CW'(1);
        else if (!in_acc && out_acc)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    `FISR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(y_bits))
    `FISR_ASSERT(a_no_phantom, !rsp_valid || (cnt_reg != '0))
    `FISR_ASSERT(a_ready_when_drained, !rsp_ready || req_ready)
    `FISR_ASSERT(a_inflight_bound, cnt_reg <= CW'(fisr_pkg::PIPE_DEPTH))

endmodule

bind fast_inverse_square_root_core fisr_checker u_fisr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .y_bits    (rsp.y_bits)
);

`default_nettype wire
